>>> rtl/gcbr_pkg.sv
// Shared constants, types and elaboration-time tables of the gamma/contrast/brightness ramp.
`timescale 1ns / 1ps
package gcbr_pkg;

  localparam int unsigned LEVELS     = 256;
  localparam int unsigned LVL_W      = 8;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned GAM_W      = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned OUT_W      = 16;

  localparam int unsigned LOG_FRAC   = 24;
  localparam int unsigned LOG_W      = 28;
  localparam int unsigned NUM_W      = 35;
  localparam int unsigned IP_W       = NUM_W - LOG_FRAC;
  localparam int unsigned DIV_BITS   = 5;
  localparam int unsigned DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned Y_W        = 33;
  localparam int unsigned T_W        = 43;
  localparam int unsigned TC_W       = 39;
  localparam int unsigned Q_W        = 24;
  localparam int unsigned RECIP_W    = 26;
  localparam int unsigned RECIP_SH   = 32;
  localparam int unsigned EXP_ZERO_IP = 33;

  localparam int unsigned PCT_MAX = 100;
  localparam int unsigned GAM_MIN = 50;
  localparam int unsigned GAM_MAX = 300;

  localparam logic [PCT_W-1:0] BRIGHT_RST = PCT_W'(50);
  localparam logic [PCT_W-1:0] CONTR_RST  = PCT_W'(50);
  localparam logic [GAM_W-1:0] GAMMA_RST  = GAM_W'(100);

  localparam logic [TC_W-1:0]     T_MAX = TC_W'(100) << 32;
  localparam logic [55:0]         RND   = 56'(50) << 32;
  localparam logic [RECIP_W-1:0]  RECIP = RECIP_W'(42949673);

  // front-end stages, divider, exp stages plus final shift, output path
  localparam int unsigned LATENCY = 2 + DIV_STAGES + LOG_FRAC + 1 + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_CONTRAST   = 2'd1,
    CFG_GAMMA      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic zero;
  } pipe_ctl_t;

  typedef logic [LOG_W-1:0] log_tbl_t [2**LVL_W];
  typedef logic [31:0]      root_tbl_t [LOG_FRAC];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v   = v_in;
    res = '0;
    for (int j = 31; j >= 0; j--) begin
      bitv = 64'd1 << (2 * j);
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  function automatic logic [LOG_W-1:0] log2_q24(input logic [63:0] n);
    logic [63:0] m;
    logic [LOG_FRAC-1:0] frac;
    int k;
    k    = 0;
    frac = '0;
    for (int j = 0; j < 31; j++) begin
      if ((n >> (j + 1)) != 0) k = j + 1;
    end
    m = n << (30 - k);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m    = (m * m) >> 30;
      frac = {frac[LOG_FRAC-2:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (LOG_W'(k) << LOG_FRAC) | LOG_W'(frac);
  endfunction

  function automatic log_tbl_t build_log_tbl();
    log_tbl_t t;
    logic [63:0] lv;
    for (int n = 0; n < 2**LVL_W; n++) begin
      lv = (n > LEVELS - 1) ? 64'(LEVELS - 1) : 64'(n);
      t[n] = (n == 0) ? '0 : log2_q24(lv);
    end
    return t;
  endfunction

  function automatic root_tbl_t build_roots();
    root_tbl_t t;
    logic [63:0] r;
    r = isqrt64(64'd1 << 63);
    for (int i = 0; i < LOG_FRAC; i++) begin
      t[i] = r[31:0];
      r    = isqrt64(r << 32);
    end
    return t;
  endfunction

  localparam log_tbl_t         LOG_TBL = build_log_tbl();
  localparam root_tbl_t        ROOTS   = build_roots();
  localparam logic [LOG_W-1:0] LOG_TOP = log2_q24(64'(LEVELS - 1));

endpackage

>>> rtl/gcbr_div.sv
// Pipelined restoring divider: exponent numerator over gamma, DIV_BITS quotient bits per stage.
`timescale 1ns / 1ps
module gcbr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gcbr_pkg::GAM_W-1:0]    gam_i,
  input  gcbr_pkg::pipe_ctl_t           ctl_i,
  input  logic [gcbr_pkg::NUM_W-1:0]    num_i,
  output gcbr_pkg::pipe_ctl_t           ctl_o,
  output logic [gcbr_pkg::NUM_W-1:0]    quo_o
);
  import gcbr_pkg::*;

  pipe_ctl_t        ctl_q [DIV_STAGES];
  logic [NUM_W-1:0] num_q [DIV_STAGES];
  logic [GAM_W-1:0] rem_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    pipe_ctl_t        ctl_in;
    logic [NUM_W-1:0] num_in, num_d;
    logic [GAM_W-1:0] rem_in, rem_d;

    if (s == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign num_in = num_i;
      assign rem_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
    end

    always_comb begin
      logic [GAM_W:0] trial;
      num_d = num_in;
      rem_d = rem_in;
      for (int j = 0; j < DIV_BITS; j++) begin
        if (s * DIV_BITS + j < NUM_W) begin
          trial = {rem_d, num_d[NUM_W-1]};
          num_d = {num_d[NUM_W-2:0], 1'b0};
          if (trial >= {1'b0, gam_i}) begin
            trial    = trial - {1'b0, gam_i};
            num_d[0] = 1'b1;
          end
          rem_d = trial[GAM_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[s] <= num_d;
      rem_q[s] <= rem_d;
    end
  end

  assign ctl_o = ctl_q[DIV_STAGES-1];
  assign quo_o = num_q[DIV_STAGES-1];

endmodule

>>> rtl/gcbr_exp.sv
// Pipelined 2^-e: one root multiply per fraction bit, then the integer shift.
`timescale 1ns / 1ps
module gcbr_exp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gcbr_pkg::pipe_ctl_t           ctl_i,
  input  logic [gcbr_pkg::NUM_W-1:0]    e_i,
  output gcbr_pkg::pipe_ctl_t           ctl_o,
  output logic [gcbr_pkg::Y_W-1:0]      y_o
);
  import gcbr_pkg::*;

  pipe_ctl_t           ctl_q  [LOG_FRAC];
  logic [31:0]         acc_q  [LOG_FRAC];
  logic                one_q  [LOG_FRAC];
  logic [IP_W-1:0]     ip_q   [LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_q [LOG_FRAC];

  pipe_ctl_t    ctl_out_q;
  logic [Y_W-1:0] y_q;

  for (genvar s = 0; s < LOG_FRAC; s++) begin : g_stage
    pipe_ctl_t           ctl_in;
    logic [31:0]         acc_in, acc_d;
    logic                one_in, one_d;
    logic [IP_W-1:0]     ip_in;
    logic [LOG_FRAC-1:0] frac_in;
    logic [63:0]         prod;

    if (s == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign acc_in  = '0;
      assign one_in  = 1'b1;
      assign ip_in   = e_i[NUM_W-1:LOG_FRAC];
      assign frac_in = e_i[LOG_FRAC-1:0];
    end else begin : g_next
      assign ctl_in  = ctl_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign one_in  = one_q[s-1];
      assign ip_in   = ip_q[s-1];
      assign frac_in = frac_q[s-1];
    end

    assign prod = 64'(acc_in) * 64'(ROOTS[s]);

    always_comb begin
      acc_d = acc_in;
      one_d = one_in;
      if (frac_in[LOG_FRAC-1-s]) begin
        acc_d = one_in ? ROOTS[s] : prod[63:32];
        one_d = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[s]  <= acc_d;
      one_q[s]  <= one_d;
      ip_q[s]   <= ip_in;
      frac_q[s] <= frac_in;
    end
  end

  logic [Y_W-1:0] base;
  logic [Y_W-1:0] y_d;

  assign base = one_q[LOG_FRAC-1] ? (Y_W'(1) << 32) : {1'b0, acc_q[LOG_FRAC-1]};

  always_comb begin
    if (ctl_q[LOG_FRAC-1].zero || ip_q[LOG_FRAC-1] >= IP_W'(EXP_ZERO_IP)) begin
      y_d = '0;
    end else begin
      y_d = base >> ip_q[LOG_FRAC-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_out_q <= '0;
    end else begin
      ctl_out_q <= ctl_q[LOG_FRAC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  assign ctl_o = ctl_out_q;
  assign y_o   = y_q;

endmodule

>>> rtl/gcbr_out.sv
// Contrast and brightness, clamp, and rounding to the 16-bit ramp word.
`timescale 1ns / 1ps
module gcbr_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gcbr_pkg::pipe_ctl_t           ctl_i,
  input  logic [gcbr_pkg::Y_W-1:0]      y_i,
  input  logic [gcbr_pkg::PCT_W-1:0]    bright_i,
  input  logic [gcbr_pkg::PCT_W-1:0]    contr_i,
  output logic                          done_o,
  output logic [gcbr_pkg::OUT_W-1:0]    ramp_o
);
  import gcbr_pkg::*;

  logic [3:0] vld_q;

  logic signed [Y_W:0]   ydiff;
  logic signed [9:0]     c2;
  logic signed [T_W-1:0] ta_d, ta_q;
  logic [TC_W-1:0]       tc_d, tc_q;
  logic [55:0]           x;
  logic [Q_W-1:0]        q_q;
  logic [Q_W+RECIP_W-1:0] p_q;

  assign ydiff = $signed({1'b0, y_i}) - $signed({3'b001, 31'b0});
  assign c2    = $signed({2'b00, contr_i, 1'b0});
  assign ta_d  = ydiff * c2 + $signed({4'b0, bright_i, 32'b0});

  always_comb begin
    if (ta_q < 0) begin
      tc_d = '0;
    end else if (ta_q > $signed({4'b0, T_MAX})) begin
      tc_d = T_MAX;
    end else begin
      tc_d = ta_q[TC_W-1:0];
    end
  end

  assign x = {1'b0, tc_q, 16'b0} - 56'(tc_q) + RND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    ta_q <= ta_d;
    tc_q <= tc_d;
    q_q  <= x[55:32];
    p_q  <= (Q_W+RECIP_W)'(q_q) * (Q_W+RECIP_W)'(RECIP);
  end

  assign done_o = vld_q[3];
  assign ramp_o = p_q[RECIP_SH+OUT_W-1:RECIP_SH];

endmodule

>>> rtl/gamma_contrast_brightness_ramp_unit.sv
// Top level of the gamma/contrast/brightness ramp: config registers, log front end, pipeline.
`timescale 1ns / 1ps
// Usage:
//   Requests: drive level_i and pulse start_i; busy_o is always low, so a
//   request is taken at every clock edge where start_i is high, one per cycle.
//   Results: done_o is high for one cycle with ramp_value_o, after the
//   request has passed 2 front-end stages, 7 divider stages at 5 quotient bits
//   each, 24 root-multiply stages, 1 shift stage and 4 output stages.
//   Throughput: one level per cycle, set by the fully pipelined divider and
//   the one-multiply-per-stage exp chain.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 brightness,
//   1 contrast, 2 gamma); other indexes are ignored. Write only
//   while no request is in flight.
//   Reset: rst_ni clears the pipeline valids (requests in flight are dropped)
//   and loads brightness 50, contrast 50, gamma 100.
//   The receiver cannot stall: each result is shown for exactly one cycle.
module gamma_contrast_brightness_ramp_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [gcbr_pkg::LVL_W-1:0]       level_i,
  input  logic                             cfg_we_i,
  input  logic [gcbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gcbr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             done_o,
  output logic [gcbr_pkg::OUT_W-1:0]       ramp_value_o
);
  import gcbr_pkg::*;

  logic [PCT_W-1:0] bright_q, bright_d, contr_q, contr_d;
  logic [GAM_W-1:0] gam_q, gam_d;
  logic [PCT_W-1:0] bright_sat, contr_sat;
  logic [GAM_W-1:0] gam_sat;

  always_comb begin
    bright_d = bright_q;
    contr_d  = contr_q;
    gam_d    = gam_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BRIGHTNESS: bright_d = cfg_data_i[PCT_W-1:0];
        CFG_CONTRAST:   contr_d  = cfg_data_i[PCT_W-1:0];
        CFG_GAMMA:      gam_d    = cfg_data_i[GAM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RST;
      contr_q  <= CONTR_RST;
      gam_q    <= GAMMA_RST;
    end else begin
      bright_q <= bright_d;
      contr_q  <= contr_d;
      gam_q    <= gam_d;
    end
  end

  assign bright_sat = (bright_q > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : bright_q;
  assign contr_sat  = (contr_q > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : contr_q;
  assign gam_sat    = (gam_q < GAM_W'(GAM_MIN)) ? GAM_W'(GAM_MIN) :
                      (gam_q > GAM_W'(GAM_MAX)) ? GAM_W'(GAM_MAX) : gam_q;

  assign busy_o = 1'b0;

  // front end: log lookup and distance, then numerator d*100 + g/2
  pipe_ctl_t        ctl0_q, ctl1_q;
  logic [LOG_W-1:0] lb, d0_q;
  logic [NUM_W-1:0] n1_q;

  assign lb = LOG_TBL[level_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
      ctl1_q <= '0;
    end else begin
      ctl0_q <= '{valid: start_i && !busy_o, zero: level_i == '0};
      ctl1_q <= ctl0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q <= (LOG_TOP > lb) ? LOG_TOP - lb : '0;
    n1_q <= NUM_W'(d0_q) * NUM_W'(100) + NUM_W'(gam_sat >> 1);
  end

  pipe_ctl_t        ctl_div, ctl_exp;
  logic [NUM_W-1:0] e_div;
  logic [Y_W-1:0]   y_exp;

  gcbr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .gam_i  (gam_sat),
    .ctl_i  (ctl1_q),
    .num_i  (n1_q),
    .ctl_o  (ctl_div),
    .quo_o  (e_div)
  );

  gcbr_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_div),
    .e_i    (e_div),
    .ctl_o  (ctl_exp),
    .y_o    (y_exp)
  );

  gcbr_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_exp),
    .y_i      (y_exp),
    .bright_i (bright_sat),
    .contr_i  (contr_sat),
    .done_o   (done_o),
    .ramp_o   (ramp_value_o)
  );

  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY done_o)
    else $error("request produced no result");

  a_result_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result without request");

  a_black_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start_i && level_i == '0 && bright_sat <= contr_sat, LATENCY))
      |-> ramp_value_o == '0)
    else $error("black level not zero");

endmodule
